### src/dimension_order_first_hop_core_defines.svh
// assertion macros shared by the checker
`ifndef DIMENSION_ORDER_FIRST_HOP_CORE_DEFINES_SVH
`define DIMENSION_ORDER_FIRST_HOP_CORE_DEFINES_SVH

// same-cycle implication, masked in reset
`define DFH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfh check failed");

// next-cycle implication, masked in reset
`define DFH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfh check failed");

`endif

### src/dfh_pkg.sv
package dfh_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int RANK_BITS = 16;
  localparam int DIM_W     = $clog2(MAX_DIMS);
  localparam int ND_W      = 3;
  localparam int PROD_W    = RANK_BITS + 1;
  localparam int MUL_W     = RANK_BITS + PROD_W;
  localparam int REL_W     = MUL_W + 1;
  localparam int N_CELLS   = MAX_DIMS * RANK_BITS;
  localparam int CFG_IDX_W = 3;

  typedef logic [RANK_BITS-1:0] rank_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [MUL_W-1:0]     mul_t;

  localparam prod_t PROD_CAP = prod_t'(64'd1 << RANK_BITS);
  localparam prod_t PROD_SAT = prod_t'((64'd1 << RANK_BITS) + 64'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT = 3'd0,
    CFG_DIM_COUNT  = 3'd1,
    CFG_SIZE_A     = 3'd2,
    CFG_SIZE_B     = 3'd3,
    CFG_SIZE_C     = 3'd4,
    CFG_SIZE_D     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    rank_t                     node_count;
    logic [ND_W-1:0]           nd;
    rank_t [MAX_DIMS-1:0]      size;
  } cfg_t;

  typedef struct packed {
    rank_t                src;
    rank_t                dst;
    rank_t                s_num;
    rank_t                d_num;
    rank_t                s_rem;
    rank_t                d_rem;
    rank_t [MAX_DIMS-1:0] cs;
    rank_t [MAX_DIMS-1:0] cd;
    prod_t [MAX_DIMS-1:0] w;
    prod_t                prod;
  } ctx_t;

endpackage

### src/dfh_if.sv
interface dfh_in_if import dfh_pkg::*; ();
  logic  valid;
  logic  ready;
  rank_t src_rank;
  rank_t dst_rank;
  modport source (output valid, src_rank, dst_rank, input ready);
  modport sink (input valid, src_rank, dst_rank, output ready);
endinterface

interface dfh_out_if import dfh_pkg::*; ();
  logic  valid;
  logic  ready;
  rank_t first_hop;
  logic  direct;
  logic  bad_request;
  modport source (output valid, first_hop, direct, bad_request, input ready);
  modport sink (input valid, first_hop, direct, bad_request, output ready);
endinterface

### src/dimension_order_first_hop_core.sv
// Dimension-order first hop on a mixed-radix mesh. One src/dst request is taken per
// cycle while the pipeline is not stalled by the result side. There are 64 division
// cells and two finishing stages, and the last finishing stage drives the output.
// Each cell resolves one quotient bit of both ranks, sixteen cells per dimension,
// four dimensions. The user must write configuration only while no request is in
// flight; the block itself does not enforce it.
module dimension_order_first_hop_core import dfh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  dfh_in_if.sink               in_ch,
  dfh_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  rank_t                cfg_data
);

  rank_t            node_count_r;
  logic [ND_W-1:0]  dim_count_r;
  rank_t [MAX_DIMS-1:0] size_r;
  cfg_t             cfg;
  logic [N_CELLS:0] vld;
  logic [N_CELLS:0] rdy;
  ctx_t             ctx [N_CELLS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= rank_t'(2);
      dim_count_r  <= ND_W'(1);
      size_r[0]    <= rank_t'(2);
      for (int i = 1; i < MAX_DIMS; i++) begin
        size_r[i] <= rank_t'(1);
      end
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NODE_COUNT: node_count_r <= cfg_data;
        CFG_DIM_COUNT:  dim_count_r  <= cfg_data[ND_W-1:0];
        CFG_SIZE_A:     size_r[0]    <= cfg_data;
        CFG_SIZE_B:     size_r[1]    <= cfg_data;
        CFG_SIZE_C:     size_r[2]    <= cfg_data;
        CFG_SIZE_D:     size_r[3]    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.node_count = node_count_r;
    cfg.size       = size_r;
    if (dim_count_r == '0) begin
      cfg.nd = ND_W'(1);
    end else if (dim_count_r > ND_W'(MAX_DIMS)) begin
      cfg.nd = ND_W'(MAX_DIMS);
    end else begin
      cfg.nd = dim_count_r;
    end
  end

  always_comb begin
    ctx[0]       = '0;
    ctx[0].src   = in_ch.src_rank;
    ctx[0].dst   = in_ch.dst_rank;
    ctx[0].s_num = in_ch.src_rank;
    ctx[0].d_num = in_ch.dst_rank;
    ctx[0].prod  = PROD_W'(1);
  end

  assign vld[0]      = in_ch.valid;
  assign in_ch.ready = rdy[0];

  for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
    dfh_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (cfg),
      .dim_pos   (DIM_W'(c / RANK_BITS)),
      .last_bit  ((c % RANK_BITS) == (RANK_BITS - 1)),
      .in_valid  (vld[c]),
      .in_ready  (rdy[c]),
      .in_ctx    (ctx[c]),
      .out_valid (vld[c+1]),
      .out_ready (rdy[c+1]),
      .out_ctx   (ctx[c+1])
    );
  end

  dfh_fin u_fin (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (vld[N_CELLS]),
    .in_ready    (rdy[N_CELLS]),
    .in_ctx      (ctx[N_CELLS]),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .first_hop   (out_ch.first_hop),
    .direct      (out_ch.direct),
    .bad_request (out_ch.bad_request)
  );

endmodule

### src/dfh_cell.sv
module dfh_cell import dfh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic [DIM_W-1:0] dim_pos,
  input  logic             last_bit,
  input  logic             in_valid,
  output logic             in_ready,
  input  ctx_t             in_ctx,
  output logic             out_valid,
  input  logic             out_ready,
  output ctx_t             out_ctx
);

  logic              valid_r;
  ctx_t              ctx_r;
  ctx_t              ctx_nxt;
  logic [ND_W-1:0]   idx_w;
  logic [DIM_W-1:0]  dim_idx;
  logic              in_use;
  logic              act;
  rank_t             sz;
  logic [RANK_BITS:0] rs_s, rs_d, r17_s, r17_d;
  logic              ge_s, ge_d;
  mul_t              mul;

  always_comb begin
    idx_w   = cfg.nd - ND_W'(1) - ND_W'(dim_pos);
    dim_idx = idx_w[DIM_W-1:0];
    in_use  = ND_W'(dim_pos) < cfg.nd;
    sz      = cfg.size[dim_idx];
    act     = in_use && (sz != '0);
    r17_s   = {in_ctx.s_rem, in_ctx.s_num[RANK_BITS-1]};
    r17_d   = {in_ctx.d_rem, in_ctx.d_num[RANK_BITS-1]};
    ge_s    = r17_s >= {1'b0, sz};
    ge_d    = r17_d >= {1'b0, sz};
    rs_s    = ge_s ? (r17_s - {1'b0, sz}) : r17_s;
    rs_d    = ge_d ? (r17_d - {1'b0, sz}) : r17_d;
    mul     = MUL_W'(in_ctx.prod) * MUL_W'(sz);
    ctx_nxt = in_ctx;
    if (act) begin
      ctx_nxt.s_rem = rs_s[RANK_BITS-1:0];
      ctx_nxt.d_rem = rs_d[RANK_BITS-1:0];
      ctx_nxt.s_num = {in_ctx.s_num[RANK_BITS-2:0], ge_s};
      ctx_nxt.d_num = {in_ctx.d_num[RANK_BITS-2:0], ge_d};
    end
    if (last_bit && in_use) begin
      ctx_nxt.w[dim_idx]  = in_ctx.prod;
      ctx_nxt.cs[dim_idx] = act ? rs_s[RANK_BITS-1:0] : '0;
      ctx_nxt.cd[dim_idx] = act ? rs_d[RANK_BITS-1:0] : '0;
      ctx_nxt.s_rem       = '0;
      ctx_nxt.d_rem       = '0;
      ctx_nxt.prod        = (mul > MUL_W'(PROD_CAP)) ? PROD_SAT : mul[PROD_W-1:0];
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_ctx   = ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      ctx_r <= ctx_nxt;
    end
  end

endmodule

### src/dfh_fin.sv
module dfh_fin import dfh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  ctx_t  in_ctx,
  output logic  out_valid,
  input  logic  out_ready,
  output rank_t first_hop,
  output logic  direct,
  output logic  bad_request
);

  logic             va_r, vb_r;
  rank_t            src_a_r, dst_a_r;
  logic             bad_a_r, bad_a_nxt;
  mul_t             ps_a_r, pd_a_r, ps_a_nxt, pd_a_nxt;
  logic             found;
  logic [DIM_W-1:0] k;
  logic             rdy_b;
  logic [REL_W-1:0] relay;
  logic             bad_b, dir_b;
  rank_t            hop_b;
  rank_t            hop_r;
  logic             direct_r, bad_r;

  // first differing dimension and the two weighted coordinates
  always_comb begin
    found = 1'b0;
    k     = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (!found && (ND_W'(i) < cfg.nd) && (in_ctx.cs[i] != in_ctx.cd[i])) begin
        found = 1'b1;
        k     = DIM_W'(i);
      end
    end
    bad_a_nxt = (in_ctx.src == in_ctx.dst) || (in_ctx.src >= cfg.node_count) ||
                (in_ctx.dst >= cfg.node_count) ||
                (PROD_W'(cfg.node_count) > in_ctx.prod) || !found;
    ps_a_nxt  = MUL_W'(in_ctx.cs[k]) * MUL_W'(in_ctx.w[k]);
    pd_a_nxt  = MUL_W'(in_ctx.cd[k]) * MUL_W'(in_ctx.w[k]);
  end

  always_comb begin
    relay = REL_W'(src_a_r) + REL_W'(pd_a_r) - REL_W'(ps_a_r);
    bad_b = bad_a_r || (relay > REL_W'({RANK_BITS{1'b1}}));
    dir_b = !bad_b && (relay[RANK_BITS-1:0] == dst_a_r);
    hop_b = bad_b ? '0 : (dir_b ? src_a_r : relay[RANK_BITS-1:0]);
  end

  assign rdy_b       = !vb_r || out_ready;
  assign in_ready    = !va_r || rdy_b;
  assign out_valid   = vb_r;
  assign first_hop   = hop_r;
  assign direct      = direct_r;
  assign bad_request = bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (in_ready) begin
        va_r <= in_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
    end
    if (in_ready && in_valid) begin
      src_a_r <= in_ctx.src;
      dst_a_r <= in_ctx.dst;
      bad_a_r <= bad_a_nxt;
      ps_a_r  <= ps_a_nxt;
      pd_a_r  <= pd_a_nxt;
    end
    if (rdy_b && va_r) begin
      hop_r    <= hop_b;
      direct_r <= dir_b;
      bad_r    <= bad_b;
    end
  end

endmodule

### src/dfh_chk.sv
`include "dimension_order_first_hop_core_defines.svh"

module dfh_chk import dfh_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  out_valid,
  input logic  out_ready,
  input rank_t first_hop,
  input logic  direct,
  input logic  bad_request
);

  `DFH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(first_hop))
  `DFH_ASSERT_IMP(a_bad_clean, out_valid && bad_request, first_hop == '0 && !direct)
  `DFH_ASSERT_IMP(a_direct_ok, out_valid && direct, !bad_request)
  `DFH_ASSERT_IMP(a_reset_empty, $rose(rst_n), !out_valid)

endmodule

bind dimension_order_first_hop_core dfh_chk u_dfh_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .first_hop   (out_ch.first_hop),
  .direct      (out_ch.direct),
  .bad_request (out_ch.bad_request)
);

### tb/dimension_order_first_hop_core_tb.sv
`timescale 1ns / 100ps

module dimension_order_first_hop_core_tb;
  import dfh_pkg::*;

  class hop_scoreboard;
    typedef struct {
      rank_t hop;
      logic  direct;
      logic  bad;
    } hop_t;

    rank_t           node_count;
    logic [ND_W-1:0] dim_count;
    rank_t           dim_size[MAX_DIMS];
    hop_t            pending[$];
    int              errors;

    function new();
      errors = 0;
      reset_regs();
    endfunction

    function void reset_regs();
      node_count = 2;
      dim_count = 1;
      dim_size[0] = 2;
      dim_size[1] = 1;
      dim_size[2] = 1;
      dim_size[3] = 1;
    endfunction

    function void write_reg(cfg_idx_t idx, rank_t v);
      case (idx)
        CFG_NODE_COUNT: node_count = v;
        CFG_DIM_COUNT:  dim_count = v[ND_W-1:0];
        CFG_SIZE_A:     dim_size[0] = v;
        CFG_SIZE_B:     dim_size[1] = v;
        CFG_SIZE_C:     dim_size[2] = v;
        CFG_SIZE_D:     dim_size[3] = v;
        default: ;
      endcase
    endfunction

    function void note_request(rank_t src, rank_t dst);
      longint unsigned cap, prod, s, d, sz, relay;
      longint unsigned cs[MAX_DIMS], cd[MAX_DIMS], w[MAX_DIMS];
      int   nd, k;
      bit   bad;
      hop_t r;
      cap = 64'd1 << RANK_BITS;
      prod = 1;
      s = src;
      d = dst;
      relay = 0;
      k = -1;
      nd = dim_count;
      if (nd < 1) nd = 1;
      if (nd > MAX_DIMS) nd = MAX_DIMS;
      for (int i = nd - 1; i >= 0; i--) begin
        sz = dim_size[i];
        w[i] = prod;
        if (sz == 0) begin
          cs[i] = 0;
          cd[i] = 0;
        end else begin
          cs[i] = s % sz;
          cd[i] = d % sz;
          s = s / sz;
          d = d / sz;
        end
        prod = prod * sz;
        if (prod > cap) prod = cap + 1;
      end
      bad = (src == dst) || (src >= node_count) || (dst >= node_count) || (node_count > prod);
      if (!bad) begin
        for (int i = 0; i < nd; i++) begin
          if (k < 0 && cs[i] != cd[i]) k = i;
        end
        if (k < 0) begin
          bad = 1;
        end else begin
          relay = longint'(src) - cs[k] * w[k] + cd[k] * w[k];
          if (relay >= cap) bad = 1;
        end
      end
      if (bad) begin
        r.hop = '0;
        r.direct = 0;
        r.bad = 1;
      end else if (relay == dst) begin
        r.hop = src;
        r.direct = 1;
        r.bad = 0;
      end else begin
        r.hop = rank_t'(relay);
        r.direct = 0;
        r.bad = 0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(rank_t hop, logic direct, logic bad);
      hop_t e;
      if (pending.size() == 0) begin
        $error("unexpected result first_hop=%0d direct=%0b bad_request=%0b", hop, direct, bad);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (hop !== e.hop) begin
        $error("first_hop expected %0d actual %0d", e.hop, hop);
        errors++;
      end
      if (direct !== e.direct) begin
        $error("direct expected %0b actual %0b", e.direct, direct);
        errors++;
      end
      if (bad !== e.bad) begin
        $error("bad_request expected %0b actual %0b", e.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  rank_t                cfg_data;
  int unsigned          cycles;
  bit                   no_idle;
  bit                   hold_req;
  hop_scoreboard        routes;

  dfh_in_if  in_ch();
  dfh_out_if out_ch();

  dimension_order_first_hop_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) routes.note_request(in_ch.src_rank, in_ch.dst_rank);
    if (rst_n && out_ch.valid && out_ch.ready)
      routes.check_result(out_ch.first_hop, out_ch.direct, out_ch.bad_request);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    int g;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = g - 1;
        end
      end
    end
  end

  task automatic send_request(rank_t src, rank_t dst);
    int g;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.src_rank <= src;
    in_ch.dst_rank <= dst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (routes.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, rank_t v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    routes.write_reg(idx, v);
  endtask

  task automatic set_mesh(rank_t nc, rank_t nd, rank_t a, rank_t b, rank_t c, rank_t d);
    write_reg(CFG_NODE_COUNT, nc);
    write_reg(CFG_DIM_COUNT, nd);
    write_reg(CFG_SIZE_A, a);
    write_reg(CFG_SIZE_B, b);
    write_reg(CFG_SIZE_C, c);
    write_reg(CFG_SIZE_D, d);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_requests(int n);
    rank_t s, d;
    int    r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 3 || routes.node_count < 2) begin
        s = rank_t'($urandom);
        d = rank_t'($urandom);
      end else begin
        s = rank_t'($urandom_range(0, routes.node_count - 1));
        d = (r == 3) ? s : rank_t'($urandom_range(0, routes.node_count - 1));
      end
      send_request(s, d);
    end
  endtask

  task automatic random_mesh();
    longint unsigned prod;
    rank_t sz[MAX_DIMS];
    rank_t nd, nc;
    int    used;
    nd = rank_t'($urandom_range(0, 7));
    used = (nd < 1) ? 1 : (nd > MAX_DIMS) ? MAX_DIMS : int'(nd);
    prod = 1;
    for (int i = 0; i < MAX_DIMS; i++) begin
      sz[i] = ($urandom_range(0, 15) == 0) ? rank_t'($urandom_range(0, 300))
                                            : rank_t'($urandom_range(1, 12));
      if (i < used) prod = prod * sz[i];
    end
    if (prod > 65535) prod = 65535;
    if (prod < 2) nc = 2;
    else if ($urandom_range(0, 9) == 0) nc = (prod == 65535) ? 16'd65535 : rank_t'(prod + 1);
    else nc = rank_t'($urandom_range(2, prod));
    set_mesh(nc, nd, sz[0], sz[1], sz[2], sz[3]);
  endtask

  initial begin
    routes = new();
    cycles = 0;
    no_idle = 0;
    hold_req = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.src_rank = '0;
    in_ch.dst_rank = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset mesh: two nodes in one dimension
    send_request(0, 1);
    send_request(1, 0);
    send_request(0, 0);
    send_request(2, 1);
    send_request(16'hffff, 0);
    drain();

    set_mesh(24, 3, 2, 3, 4, 1);
    send_request(0, 23);
    send_request(5, 6);
    send_request(23, 0);
    send_request(4, 16);
    send_request(24, 3);
    random_requests(30);
    drain();

    // relay too wide when the product passes the rank range
    set_mesh(16'hffff, 2, 300, 300, 1, 1);
    send_request(200, 65400);
    send_request(65000, 100);
    send_request(16'hfffe, 0);
    send_request(0, 16'hffff);
    random_requests(30);
    drain();

    no_idle = 1;
    set_mesh(16'hffff, 4, 16, 16, 16, 16);
    hold_req = 1;
    send_request(0, 16'hfffe);
    send_request(16'hfffe, 1);
    random_requests(120);
    drain();
    no_idle = 0;

    set_mesh(2, 1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_request(0, 1);
    send_request(1, 0);
    random_requests(15);
    drain();

    // dimension count zero acts as one
    set_mesh(8, 0, 10, 3, 3, 3);
    random_requests(25);
    drain();

    // dimension count above the maximum
    set_mesh(60, 7, 3, 4, 5, 1);
    random_requests(30);
    drain();

    // zero size always errors
    set_mesh(50, 2, 0, 7, 1, 1);
    random_requests(15);
    drain();

    // node count above the product
    set_mesh(200, 3, 5, 5, 5, 1);
    random_requests(15);
    drain();

    for (int p = 0; p < 6; p++) begin
      random_mesh();
      if (p == 3) hold_req = 1;
      random_requests(55);
      drain();
    end

    repeat (20) @(posedge clk);
    if (routes.errors == 0 && routes.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
